FILE: design/sle_pkg.sv
// Shared types, constants and the keyboard layout lookup for the scancode line editor.
package sle_pkg;

  // Line storage geometry.
  localparam int LINE_CAPACITY = 64;
  localparam int STORE_DEPTH   = 64;
  localparam int CNT_W         = $clog2(STORE_DEPTH);
  localparam int LINE_LIMIT    = (LINE_CAPACITY - 1 > STORE_DEPTH - 1) ?
                                 STORE_DEPTH - 1 : LINE_CAPACITY - 1;

  // Scancodes with a fixed meaning.
  localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
  localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
  localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
  localparam int         SC_BREAK_BIT    = 7;

  // Characters with a fixed meaning.
  localparam logic [6:0] CH_NONE      = 7'h00;
  localparam logic [6:0] CH_BACKSPACE = 7'h08;
  localparam logic [6:0] CH_NEWLINE   = 7'h0A;
  localparam logic [6:0] CH_LOWER_A   = 7'h61;
  localparam logic [6:0] CH_LOWER_Z   = 7'h7A;
  localparam logic [6:0] CASE_OFFSET  = 7'd32;

  // Result kinds.
  localparam logic KIND_ECHO = 1'b0;
  localparam logic KIND_LINE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DUMP
  } st_t;

  // US layout for set-1 make codes; codes without a character give zero.
  function automatic logic [6:0] layout_char(input logic [6:0] code);
    logic [6:0] ch;
    unique case (code)
      7'd1:    ch = 7'h1B;
      7'd2:    ch = 7'h31;
      7'd3:    ch = 7'h32;
      7'd4:    ch = 7'h33;
      7'd5:    ch = 7'h34;
      7'd6:    ch = 7'h35;
      7'd7:    ch = 7'h36;
      7'd8:    ch = 7'h37;
      7'd9:    ch = 7'h38;
      7'd10:   ch = 7'h39;
      7'd11:   ch = 7'h30;
      7'd12:   ch = 7'h2D;
      7'd13:   ch = 7'h3D;
      7'd14:   ch = CH_BACKSPACE;
      7'd15:   ch = 7'h09;
      7'd16:   ch = 7'h71;
      7'd17:   ch = 7'h77;
      7'd18:   ch = 7'h65;
      7'd19:   ch = 7'h72;
      7'd20:   ch = 7'h74;
      7'd21:   ch = 7'h79;
      7'd22:   ch = 7'h75;
      7'd23:   ch = 7'h69;
      7'd24:   ch = 7'h6F;
      7'd25:   ch = 7'h70;
      7'd26:   ch = 7'h5B;
      7'd27:   ch = 7'h5D;
      7'd28:   ch = CH_NEWLINE;
      7'd30:   ch = 7'h61;
      7'd31:   ch = 7'h73;
      7'd32:   ch = 7'h64;
      7'd33:   ch = 7'h66;
      7'd34:   ch = 7'h67;
      7'd35:   ch = 7'h68;
      7'd36:   ch = 7'h6A;
      7'd37:   ch = 7'h6B;
      7'd38:   ch = 7'h6C;
      7'd39:   ch = 7'h3B;
      7'd40:   ch = 7'h27;
      7'd41:   ch = 7'h60;
      7'd43:   ch = 7'h5C;
      7'd44:   ch = 7'h7A;
      7'd45:   ch = 7'h78;
      7'd46:   ch = 7'h63;
      7'd47:   ch = 7'h76;
      7'd48:   ch = 7'h62;
      7'd49:   ch = 7'h6E;
      7'd50:   ch = 7'h6D;
      7'd51:   ch = 7'h2C;
      7'd52:   ch = 7'h2E;
      7'd53:   ch = 7'h2F;
      7'd55:   ch = 7'h2A;
      7'd57:   ch = 7'h20;
      default: ch = CH_NONE;
    endcase
    return ch;
  endfunction

endpackage

FILE: design/scancode_line_editor.sv
// Top level of the scancode line editor: decode, line control and result register.
//
// The block takes one set-1 keyboard scancode per input transfer and produces
// zero or more result transfers. Shift press and release codes only track the
// held-shift flag; other release codes and make codes without a character are
// dropped. A printable key is upper-cased for letters under shift and, unless
// the line is full, stored in the line memory and echoed. Backspace removes
// the last stored character and echoes a backspace, and does nothing on an
// empty line. Newline echoes a newline and then delivers every stored
// character in order as line results, with out_last set on the final result
// of the scancode, and empties the line. Each scancode is accepted in the idle
// state, then decoded and acted on in the decode state, which waits while the
// result register is still held by the consumer. A newline then delivers the
// stored characters from the dump state through the single read port of the
// line memory, whose read for a character is issued ahead of its load into
// the result register. Reset clears the shift flag and the line length; the
// line memory needs no clearing since only written entries are ever read.
module scancode_line_editor
  import sle_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_scan_code,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_kind,
  output logic [6:0] out_char_code,
  output logic       out_last
);

  st_t              state_r, state_nxt;
  logic [7:0]       code_r;
  logic             shift_r, shift_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_kind_r, out_kind_nxt;
  logic [6:0]       out_char_r, out_char_nxt;
  logic             out_last_r, out_last_nxt;

  // Line memory port signals.
  logic             ram_we;
  logic [CNT_W-1:0] ram_waddr;
  logic [6:0]       ram_wdata;
  logic             ram_re;
  logic [CNT_W-1:0] ram_raddr;
  logic [6:0]       ram_rdata;

  // Decode of the held scancode.
  logic       is_release;
  logic       is_shift_make;
  logic       is_shift_break;
  logic [6:0] key_char;
  logic [6:0] cased_char;
  logic       act_newline;
  logic       act_backspace;
  logic       act_store;
  logic       needs_out;
  logic       slot_free;
  logic       proceed;
  logic       line_empty;
  logic       line_full;
  logic       dump_last;

  assign is_shift_make  = (code_r == SC_LSHIFT_MAKE) || (code_r == SC_RSHIFT_MAKE);
  assign is_shift_break = (code_r == SC_LSHIFT_BREAK) || (code_r == SC_RSHIFT_BREAK);
  assign is_release     = code_r[SC_BREAK_BIT];
  assign key_char       = layout_char(code_r[6:0]);
  assign line_empty     = (cnt_r == '0);
  assign line_full      = (cnt_r >= LINE_LIMIT[CNT_W-1:0]);

  assign cased_char = (shift_r && key_char >= CH_LOWER_A && key_char <= CH_LOWER_Z) ?
                      key_char - CASE_OFFSET : key_char;

  assign act_newline   = !is_release && (key_char == CH_NEWLINE);
  assign act_backspace = !is_release && (key_char == CH_BACKSPACE) && !line_empty;
  assign act_store     = !is_release && !is_shift_make && (key_char != CH_NONE) &&
                         (key_char != CH_NEWLINE) && (key_char != CH_BACKSPACE) &&
                         !line_full;
  assign needs_out     = act_newline || act_backspace || act_store;

  // The result register can take a new result when empty or being drained.
  assign slot_free = !out_valid_r || out_ready;
  assign proceed   = !needs_out || slot_free;
  assign dump_last = (idx_r == cnt_r - {{(CNT_W-1){1'b0}}, 1'b1});

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (proceed) begin
          state_nxt = (act_newline && !line_empty) ? ST_DUMP : ST_IDLE;
        end
      end
      ST_DUMP: begin
        if (slot_free && dump_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs, line control and memory accesses. The store write happens only
  // while decoding a printable key, and reads only for a newline, so a write
  // and a read to the same entry never overlap within one scancode.
  always_comb begin
    in_ready      = 1'b0;
    shift_nxt     = shift_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt  = out_kind_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    ram_we        = 1'b0;
    ram_waddr     = cnt_r;
    ram_wdata     = cased_char;
    ram_re        = 1'b0;
    ram_raddr     = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_DECODE: begin
        if (proceed) begin
          if (is_shift_make) begin
            shift_nxt = 1'b1;
          end else if (is_shift_break) begin
            shift_nxt = 1'b0;
          end
          if (act_newline) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_ECHO;
            out_char_nxt  = CH_NEWLINE;
            out_last_nxt  = line_empty;
            // Fetch the first stored character ahead of the line dump.
            idx_nxt       = '0;
            ram_re        = 1'b1;
            ram_raddr     = '0;
          end else if (act_backspace) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_ECHO;
            out_char_nxt  = CH_BACKSPACE;
            out_last_nxt  = 1'b1;
            cnt_nxt       = cnt_r - {{(CNT_W-1){1'b0}}, 1'b1};
          end else if (act_store) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_ECHO;
            out_char_nxt  = cased_char;
            out_last_nxt  = 1'b1;
            ram_we        = 1'b1;
            cnt_nxt       = cnt_r + {{(CNT_W-1){1'b0}}, 1'b1};
          end
        end
      end
      ST_DUMP: begin
        // The read data for idx_r holds until the next read is issued.
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_LINE;
          out_char_nxt  = ram_rdata;
          out_last_nxt  = dump_last;
          if (dump_last) begin
            cnt_nxt = '0;
          end else begin
            idx_nxt   = idx_r + {{(CNT_W-1){1'b0}}, 1'b1};
            ram_re    = 1'b1;
            ram_raddr = idx_r + {{(CNT_W-1){1'b0}}, 1'b1};
          end
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      shift_r     <= 1'b0;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      shift_r     <= shift_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      code_r <= in_scan_code;
    end
    out_kind_r <= out_kind_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  sle_ram #(
    .WIDTH(7),
    .DEPTH(STORE_DEPTH)
  ) u_line_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_char_code = out_char_r;
  assign out_last      = out_last_r;

`ifndef SYNTHESIS
  // The stored line never grows past its limit.
  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LINE_LIMIT[CNT_W-1:0])
    else $error("line length exceeds its limit");

  // The line dump only walks entries that hold characters.
  a_dump_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DUMP) |-> (idx_r < cnt_r))
    else $error("line dump index beyond stored length");

  // An accepted scancode moves the block into the decode state in the following cycle.
  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_DECODE))
    else $error("accepted scancode not decoded");

  // The line is empty once a dump has delivered its final character.
  a_dump_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DUMP && slot_free && dump_last) |=> (cnt_r == '0))
    else $error("line not emptied after delivery");
`endif

endmodule

FILE: design/sle_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module sle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: dv/scancode_line_editor_checker.sv
// Checker for the scancode line editor: predicts results from accepted scancodes and compares.
module scancode_line_editor_checker
  import sle_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_scan_code,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic       out_kind,
  input  logic [6:0] out_char_code,
  input  logic       out_last,
  output int         expected_left,
  output int         fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       kind;
    logic [6:0] char_code;
    logic       last;
  } line_result_t;

  // Shadow copy of the editor state.
  bit               shift_held;
  logic [CNT_W-1:0] line_count;
  logic [6:0]       line_store [STORE_DEPTH];
  logic [6:0]       keymap [128];

  line_result_t     pending_chars [$];
  line_result_t     oldest;

  task automatic fill_row(input int first, input string chars);
    for (int i = 0; i < chars.len(); i++) begin
      keymap[first + i] = 7'(chars[i]);
    end
  endtask

  // US layout for set-1 make codes, built from the keyboard rows.
  initial begin
    foreach (keymap[i]) keymap[i] = CH_NONE;
    keymap[1]  = 7'h1B;
    fill_row(2, "1234567890-=");
    keymap[14] = CH_BACKSPACE;
    keymap[15] = 7'h09;
    fill_row(16, "qwertyuiop[]");
    keymap[28] = CH_NEWLINE;
    fill_row(30, "asdfghjkl;'");
    keymap[41] = 7'h60;
    fill_row(43, "\\zxcvbnm,./");
    keymap[55] = 7'h2A;
    keymap[57] = 7'h20;
  end

  function automatic void push_result(input logic kind, input logic [6:0] ch, input logic last);
    line_result_t r;
    r.kind      = kind;
    r.char_code = ch;
    r.last      = last;
    pending_chars.push_back(r);
  endfunction

  function automatic void predict_keystroke(input logic [7:0] code);
    logic [6:0]       ch;
    logic [CNT_W-1:0] cnt;
    if (code == SC_LSHIFT_MAKE || code == SC_RSHIFT_MAKE) begin
      shift_held = 1'b1;
      return;
    end
    if (code == SC_LSHIFT_BREAK || code == SC_RSHIFT_BREAK) begin
      shift_held = 1'b0;
      return;
    end
    if (code[SC_BREAK_BIT]) return;
    ch = keymap[code[6:0]];
    if (ch == CH_NONE) return;
    if (ch == CH_NEWLINE) begin
      cnt = line_count;
      push_result(KIND_ECHO, CH_NEWLINE, cnt == 0);
      for (int i = 0; i < cnt; i++) begin
        push_result(KIND_LINE, line_store[i], i + 1 == cnt);
      end
      line_count = '0;
      return;
    end
    if (ch == CH_BACKSPACE) begin
      if (line_count != 0) begin
        line_count = line_count - 1'b1;
        push_result(KIND_ECHO, CH_BACKSPACE, 1'b1);
      end
      return;
    end
    if (line_count >= LINE_LIMIT) return;
    if (shift_held && ch >= CH_LOWER_A && ch <= CH_LOWER_Z) ch = ch - CASE_OFFSET;
    line_store[line_count] = ch;
    line_count = line_count + 1'b1;
    push_result(KIND_ECHO, ch, 1'b1);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      shift_held = 1'b0;
      line_count = '0;
      pending_chars.delete();
      fail_count = 0;
    end else begin
      // Results are checked before this edge's scancode is predicted; a result
      // can never stem from a scancode accepted at the same edge.
      if (out_valid && out_ready) begin
        if (pending_chars.size() == 0) begin
          $error("unexpected result: kind %0d char_code 0x%02h last %0d",
                 out_kind, out_char_code, out_last);
          fail_count++;
        end else begin
          oldest = pending_chars.pop_front();
          if (out_kind !== oldest.kind) begin
            $error("kind: expected %0d, actual %0d", oldest.kind, out_kind);
            fail_count++;
          end
          if (out_char_code !== oldest.char_code) begin
            $error("char_code: expected 0x%02h, actual 0x%02h",
                   oldest.char_code, out_char_code);
            fail_count++;
          end
          if (out_last !== oldest.last) begin
            $error("last: expected %0d, actual %0d", oldest.last, out_last);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) predict_keystroke(in_scan_code);
    end
    expected_left <= pending_chars.size();
  end

endmodule

FILE: dv/scancode_line_editor_tb.sv
// Testbench top for the scancode line editor: clock, reset, keystroke stimulus and verdict.
module scancode_line_editor_tb;
  import sle_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Make codes used by the directed part and the typing sequences.
  localparam logic [7:0] KEY_NONE      = 8'h00;
  localparam logic [7:0] KEY_ESC       = 8'h01;
  localparam logic [7:0] KEY_1         = 8'h02;
  localparam logic [7:0] KEY_BACKSPACE = 8'h0E;
  localparam logic [7:0] KEY_TAB       = 8'h0F;
  localparam logic [7:0] KEY_Q         = 8'h10;
  localparam logic [7:0] KEY_ENTER     = 8'h1C;
  localparam logic [7:0] KEY_A         = 8'h1E;
  localparam logic [7:0] KEY_Z         = 8'h2C;
  localparam logic [7:0] KEY_SLASH     = 8'h35;
  localparam logic [7:0] KEY_STAR      = 8'h37;
  localparam logic [7:0] KEY_SPACE     = 8'h39;
  localparam logic [7:0] KEY_TOP_MAKE  = 8'h7F;
  localparam logic [7:0] KEY_A_BREAK   = 8'h9E;
  localparam logic [7:0] KEY_TOP_BREAK = 8'hFF;

  // Number of random items, when the full-line run starts and when the
  // receiver begins its long hold-off.
  localparam int RANDOM_ITEMS   = 100;
  localparam int FULL_LINE_AT   = 40;
  localparam int HOLD_AT        = 45;
  localparam int HOLD_CYCLES    = 250;
  // Cycles without any transfer before the run is declared hung. The longest
  // quiet stretch of a correct run is the hold-off above, so this leaves a
  // wide margin.
  localparam int WATCHDOG_LIMIT = 4000;

  logic       clk           = 1'b0;
  logic       rst_n         = 1'b0;
  logic       in_valid      = 1'b0;
  logic       in_ready;
  logic [7:0] in_scan_code  = 8'h00;
  logic       out_valid;
  logic       out_ready     = 1'b0;
  logic       out_kind;
  logic [6:0] out_char_code;
  logic       out_last;

  int expected_left;
  int fail_count;
  int offered;
  int burst_left;
  int quiet_cycles;

  scancode_line_editor uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_scan_code (in_scan_code),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .out_char_code(out_char_code),
    .out_last     (out_last)
  );

  scancode_line_editor_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_scan_code (in_scan_code),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .out_char_code(out_char_code),
    .out_last     (out_last),
    .expected_left(expected_left),
    .fail_count   (fail_count)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // The sender works in bursts. Between bursts it drops valid for a random
  // gap, usually short and now and then long; a gap of zero lets two bursts
  // run together, which gives stretches with no idling at all. Valid is only
  // lowered at the edge where the previous transfer happened and raised again
  // at a later edge, so it never gets two assignments in one step.
  task automatic offer(input logic [7:0] code);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
      if (gap > 0) begin
        in_valid     <= 1'b0;
        in_scan_code <= 8'($urandom_range(0, 255));
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_scan_code <= code;
    // The transfer happens at the first edge that sees ready high.
    do @(posedge clk); while (!in_ready);
    offered++;
  endtask

  // A random make code that carries a character: no backspace, no
  // enter, no shift and none of the modifier or unmapped keys.
  function automatic logic [7:0] pick_key();
    int c;
    do c = $urandom_range(1, 57);
    while (c == 14 || c == 28 || c == 29 || c == 42 || c == 54 || c == 56);
    return 8'(c);
  endfunction

  // One typed line: printable keys with shift presses, shift releases and
  // backspaces mixed in, closed by enter.
  task automatic type_line(input int len);
    int r;
    for (int k = 0; k < len; k++) begin
      r = $urandom_range(0, 19);
      case (r)
        0:       offer($urandom_range(0, 1) ? SC_LSHIFT_MAKE : SC_RSHIFT_MAKE);
        1:       offer($urandom_range(0, 1) ? SC_LSHIFT_BREAK : SC_RSHIFT_BREAK);
        2:       offer(KEY_BACKSPACE);
        default: offer(pick_key());
      endcase
    end
    offer(KEY_ENTER);
  endtask

  // The receiver stalls on a pattern of its own that changes after each random
  // span: always ready, coin flip, mostly stalled, or mostly ready. Once
  // the sender is well into the random part, it holds ready low for a long
  // stretch so that the block fills up and pushes back on its input.
  initial begin
    int  mode;
    int  span;
    bit  hold_done;
    hold_done = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 60);
      repeat (span) begin
        if (!hold_done && offered >= HOLD_AT) begin
          hold_done = 1'b1;
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Any cycle without a transfer on either channel counts toward the limit.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int r;
    offered    = 0;
    burst_left = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Enter on an empty line gives only the newline echo, and
    // backspace on an empty line gives nothing.
    offer(KEY_ENTER);
    offer(KEY_BACKSPACE);
    // Make codes without a character, the lowest and the highest.
    offer(KEY_NONE);
    offer(KEY_TOP_MAKE);
    // Release codes of ordinary keys are ignored.
    offer(KEY_A_BREAK);
    offer(KEY_TOP_BREAK);
    // Letters with and without shift, through both shift keys; a digit stays
    // as it is under shift.
    offer(KEY_A);
    offer(SC_LSHIFT_MAKE);
    offer(KEY_A);
    offer(KEY_Z);
    offer(KEY_1);
    offer(SC_LSHIFT_BREAK);
    offer(SC_RSHIFT_MAKE);
    offer(KEY_Q);
    offer(SC_RSHIFT_BREAK);
    offer(KEY_Z);
    // Characters at the edges of the layout: escape, tab, slash, star, space.
    offer(KEY_SPACE);
    offer(KEY_TAB);
    offer(KEY_ESC);
    offer(KEY_SLASH);
    offer(KEY_STAR);
    // Backspace on a line that has characters, then the line is delivered.
    offer(KEY_BACKSPACE);
    offer(KEY_ENTER);

    // Random part: mostly typed lines with random content, the rest
    // backspace runs, lone enters, stray releases and raw noise bytes.
    // Once, the line is typed past its capacity so that the extra keys are
    // dropped and enter delivers the longest possible line.
    r = offered;
    while (offered < r + RANDOM_ITEMS) begin
      if (offered >= r + FULL_LINE_AT && offered < r + FULL_LINE_AT + 20) begin
        for (int k = 0; k < LINE_LIMIT + 6; k++) offer(pick_key());
        offer(KEY_BACKSPACE);
        offer(pick_key());
        offer(pick_key());
        offer(KEY_ENTER);
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: type_line($urandom_range(1, 12));
        6:       repeat ($urandom_range(1, 4)) offer(KEY_BACKSPACE);
        7:       offer(8'($urandom_range(0, 255)));
        8:       offer(pick_key() | 8'h80);
        default: offer(KEY_ENTER);
      endcase
    end
    in_valid <= 1'b0;

    // The checker's count is registered, so step an edge before looking,
    // then drain and give the block time to settle.
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
design/sle_pkg.sv
design/sle_ram.sv
design/scancode_line_editor.sv
dv/scancode_line_editor_checker.sv
dv/scancode_line_editor_tb.sv
